>>> src/fqrv_pkg.sv
// ----------------------------------------------------------------------------
// fqrv_pkg: shared types and constants for the queue with remove by value
// Holds the queue geometry, operation and status codes, the sequencer states
// and the structs passed from the sequencer to the entry store and the output register.
// ----------------------------------------------------------------------------
package fqrv_pkg;

  // Queue geometry and field widths.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;

  // Operation selector carried with each request.
  typedef enum logic [1:0] {
    FN_ENQ  = 2'd0,
    FN_DEQ  = 2'd1,
    FN_REM  = 2'd2,
    FN_NOP  = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FETCH,
    S_RESULT
  } state_t;

  // Controls from the sequencer to the entry store.
  typedef struct packed {
    logic             cap_value;
    logic             we;
    logic             wr_shift;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
  } store_ctl_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic             load;
    status_t          status;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

>>> src/fqrv_store.sv
// ----------------------------------------------------------------------------
// fqrv_store: entry memory and shared compare unit
// Holds the queue entries with the head at index zero, two registered read
// ports, one write port and the single equality comparator used by the scan.
// ----------------------------------------------------------------------------
module fqrv_store
  import fqrv_pkg::*;
(
  input  logic                     clk,
  input  store_ctl_t               ctl,
  input  logic signed [DATA_W-1:0] in_value,
  output logic signed [DATA_W-1:0] rdata_a,
  output logic signed [DATA_W-1:0] rdata_b,
  output logic                     match
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] rdata_a_r;
  logic signed [DATA_W-1:0] rdata_b_r;

  // Request value is held for the whole operation.
  always_ff @(posedge clk) begin
    if (ctl.cap_value) begin
      value_r <= in_value;
    end
  end

  // Write port: either the new tail value or an entry moved down by one.
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wr_shift ? rdata_a_r : value_r;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rdata_a_r <= mem[ctl.raddr_a];
    rdata_b_r <= mem[ctl.raddr_b];
  end

  // The one comparator, checked against the entry on port A.
  assign match   = (rdata_a_r == value_r);
  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> src/fqrv_ctrl.sv
// ----------------------------------------------------------------------------
// fqrv_ctrl: operation sequencer
// Steps one request through decode, scan, shift-down and fetch of the head
// and tail, and keeps the entry count, scan index and result status.
// ----------------------------------------------------------------------------
module fqrv_ctrl
  import fqrv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  input  logic       out_free,
  input  logic       match,
  output logic       in_ready,
  output store_ctl_t ctl,
  output result_t    res
);

  state_t           state_r, state_nxt;
  func_t            func_r, func_nxt;
  status_t          status_r, status_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             full;
  logic             empty;
  logic             more;
  logic [IDX_W-1:0] idx_inc;
  logic [CNT_W-1:0] cnt_dec;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign idx_inc = idx_r + IDX_W'(1);
  // True while an entry above the current index is still held.
  assign more    = ((CNT_W'(idx_r) + CNT_W'(1)) < cnt_r);
  assign cnt_dec = cnt_r - CNT_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (func_r)
          FN_DEQ:  state_nxt = empty ? S_FETCH : S_SHIFT_RD;
          FN_REM:  state_nxt = empty ? S_FETCH : S_SCAN_RD;
          default: state_nxt = S_FETCH;
        endcase
      end
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (match)     state_nxt = S_SHIFT_RD;
        else if (more) state_nxt = S_SCAN_RD;
        else           state_nxt = S_FETCH;
      end
      S_SHIFT_RD: state_nxt = more ? S_SHIFT_WR : S_FETCH;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_FETCH:    state_nxt = S_RESULT;
      S_RESULT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Count, index, operation and status updates.
  always_comb begin
    func_nxt   = func_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = func_t'(in_func);
          status_nxt = ST_DONE;
          idx_nxt    = '0;
        end
      end
      S_DECODE: begin
        case (func_r)
          FN_ENQ: begin
            if (full) status_nxt = ST_FULL;
            else      cnt_nxt    = cnt_r + CNT_W'(1);
          end
          FN_DEQ, FN_REM: begin
            if (empty) status_nxt = ST_EMPTY;
          end
          default: ;
        endcase
      end
      S_SCAN_CMP: begin
        if (!match) begin
          if (more) idx_nxt    = idx_inc;
          else      status_nxt = ST_NOTFOUND;
        end
      end
      S_SHIFT_RD: begin
        if (!more) cnt_nxt = cnt_dec;
      end
      S_SHIFT_WR: idx_nxt = idx_inc;
      default: ;
    endcase
  end

  // Outputs to the store and the result register.
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    ctl.cap_value = (state_r == S_IDLE);
    ctl.we        = 1'b0;
    ctl.wr_shift  = 1'b0;
    ctl.waddr     = idx_r;
    ctl.raddr_a   = idx_r;
    ctl.raddr_b   = cnt_dec[IDX_W-1:0];
    res.load      = 1'b0;
    res.status    = status_r;
    res.count     = cnt_r;
    case (state_r)
      S_DECODE: begin
        if (func_r == FN_ENQ && !full) begin
          ctl.we    = 1'b1;
          ctl.waddr = cnt_r[IDX_W-1:0];
        end
      end
      S_SHIFT_RD: ctl.raddr_a = idx_inc;
      S_SHIFT_WR: begin
        ctl.we       = 1'b1;
        ctl.wr_shift = 1'b1;
      end
      S_FETCH:    ctl.raddr_a = '0;
      S_RESULT: begin
        ctl.raddr_a = '0;
        res.load    = out_free;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      idx_r    <= '0;
      func_r   <= FN_ENQ;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      func_r   <= func_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

>>> src/fifo_queue_with_remove_by_value.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_value: bounded queue with remove by value
// Top level: request and result stream ports, sequencer, entry store and
// the result output register.
// ----------------------------------------------------------------------------
// A bounded first-in first-out queue of sixteen signed 32-bit values. Each
// request selects enqueue, dequeue of the head, or removal of the entry
// nearest the head that equals the request value, and returns one result
// with a status, the entry count and the head and tail values (zero when
// empty). Entries are kept in one memory with the head at index zero and are
// visited through a single read port, one entry per step. A dequeue moves every
// remaining entry down by a read and a write, and a remove scans from the head
// for a match and then moves the entries above it down the same way. A new
// request is taken only when the sequencer is idle; a finished result may still
// wait in the output register then.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_by_value
  import fqrv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [4:0] count, [36:5] head_value,
                                  // [68:37] tail_value, [71:69] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  store_ctl_t               ctl;
  result_t                  res;
  logic                     match;
  logic                     out_free;
  logic signed [DATA_W-1:0] rdata_a;
  logic signed [DATA_W-1:0] rdata_b;

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [CNT_W-1:0]         out_count_r;
  logic signed [DATA_W-1:0] out_head_r;
  logic signed [DATA_W-1:0] out_tail_r;

  assign out_free = !out_valid_r || out_tready;

  fqrv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tuser),
    .out_free (out_free),
    .match    (match),
    .in_ready (in_tready),
    .ctl      (ctl),
    .res      (res)
  );

  fqrv_store u_store (
    .clk      (clk),
    .ctl      (ctl),
    .in_value (in_tdata),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .match    (match)
  );

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; head and tail read as zero for an empty queue.
  always_ff @(posedge clk) begin
    if (res.load) begin
      out_status_r <= res.status;
      out_count_r  <= res.count;
      out_head_r   <= (res.count == '0) ? '0 : rdata_a;
      out_tail_r   <= (res.count == '0) ? '0 : rdata_b;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_tail_r, out_head_r, out_count_r};

`ifndef SYNTHESIS
  // The count never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res.count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // A full status is only reported with the queue at depth.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res.load && res.status == ST_FULL) |-> (res.count == CNT_W'(DEPTH)))
    else $error("full status with free room");

  // After a request is taken the sequencer is busy.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while busy");
`endif

endmodule

>>> tb/sv/queue_result_checker.sv
// ----------------------------------------------------------------------------
// queue_result_checker: result checker for the queue with remove by value
// Watches the request and result streams of the queue. It keeps its own copy
// of the queue contents, predicts the result of each accepted request and
// compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module queue_result_checker
  import fqrv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] func
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,  // [4:0] count, [36:5] head_value,
                                  // [68:37] tail_value, [71:69] zero
  input  logic [1:0]  out_tuser,  // [1:0] status
  output int          mismatches,
  output int          pending
);

  // What one request should report back.
  typedef struct {
    status_t           status;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] head_value;
    logic [DATA_W-1:0] tail_value;
  } queue_snapshot_t;

  // Modeled queue contents, head first, and the snapshots still owed.
  logic [DATA_W-1:0] held[$];
  queue_snapshot_t   snapshots_due[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Apply one request to the modeled queue and return the expected snapshot.
  function automatic queue_snapshot_t apply_queue_request(input func_t fn,
                                                          input logic [31:0] val);
    queue_snapshot_t snap;
    int              hit;
    snap.status = ST_DONE;
    hit = -1;
    case (fn)
      FN_ENQ: begin
        if (held.size() >= DEPTH) snap.status = ST_FULL;
        else held.push_back(val);
      end
      FN_DEQ: begin
        if (held.size() == 0) snap.status = ST_EMPTY;
        else void'(held.pop_front());
      end
      FN_REM: begin
        if (held.size() == 0) begin
          snap.status = ST_EMPTY;
        end else begin
          // The entry nearest the head wins when values repeat.
          foreach (held[i]) if (hit < 0 && held[i] == val) hit = i;
          if (hit < 0) snap.status = ST_NOTFOUND;
          else held.delete(hit);
        end
      end
      default: ;
    endcase
    snap.count = CNT_W'(held.size());
    if (held.size() == 0) begin
      snap.head_value = '0;
      snap.tail_value = '0;
    end else begin
      snap.head_value = held[0];
      snap.tail_value = held[held.size() - 1];
    end
    return snap;
  endfunction

  // Compare one accepted result with the oldest snapshot owed.
  task automatic compare_result();
    queue_snapshot_t want;
    if (snapshots_due.size() == 0) begin
      $error("result arrived with no request outstanding");
      mismatches++;
    end else begin
      want = snapshots_due.pop_front();
      if (out_tuser != want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_tuser);
        mismatches++;
      end
      if (out_tdata[4:0] != want.count) begin
        $error("count: expected %0d, got %0d", want.count, out_tdata[4:0]);
        mismatches++;
      end
      if (out_tdata[36:5] != want.head_value) begin
        $error("head_value: expected %0d, got %0d",
               $signed(want.head_value), $signed(out_tdata[36:5]));
        mismatches++;
      end
      if (out_tdata[68:37] != want.tail_value) begin
        $error("tail_value: expected %0d, got %0d",
               $signed(want.tail_value), $signed(out_tdata[68:37]));
        mismatches++;
      end
    end
  endtask

  // Results are older than any request taken at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      held.delete();
      snapshots_due.delete();
      pending = 0;
    end else begin
      if (out_tvalid && out_tready) compare_result();
      if (in_tvalid && in_tready)
        snapshots_due.push_back(apply_queue_request(func_t'(in_tuser), in_tdata));
      pending = snapshots_due.size();
    end
  end

endmodule

>>> tb/sv/fifo_queue_with_remove_by_value_tb.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_value_tb: testbench top for the queue
// Drives directed and random enqueue, dequeue, remove and no-op requests with random
// gaps and result back-pressure, and leaves prediction and comparison to the
// result checker. Gives the verdict once all results have come back.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_by_value_tb;
  import fqrv_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  int          mismatches;
  int          pending;

  // Set for stretches in which neither side idles.
  bit          no_idle;
  // Values reused so that removes find matches and duplicates appear.
  logic [31:0] value_pool[6];

  fifo_queue_with_remove_by_value u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  queue_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4000000;
    $display("fifo_queue_with_remove_by_value_tb: FAIL");
    $finish;
  end

  // Send one request after a random gap and hold it until it is taken.
  task automatic send_request(input func_t fn, input logic [31:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = fn;
    in_tdata  = val;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold off new requests until every result is back.
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Pick a value: mostly from the pool when hits are wanted.
  function automatic logic [31:0] pick_value(input int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, 5)];
    return $urandom();
  endfunction

  // Result side: random stalls, with stretches of none.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Request stimulus and verdict.
  initial begin
    int    enq_pct;
    int    phase_len;
    int    sent;
    int    pick;
    func_t fn;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FN_ENQ;
    no_idle   = 1'b0;
    foreach (value_pool[i]) value_pool[i] = $urandom();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Operations on an empty queue.
    send_request(FN_DEQ, 32'h0000_0000);
    send_request(FN_REM, 32'h1234_5678);
    send_request(FN_NOP, 32'hFFFF_FFFF);

    // Fill to capacity with extreme values and one duplicate.
    send_request(FN_ENQ, 32'h8000_0000);
    send_request(FN_ENQ, 32'h7FFF_FFFF);
    send_request(FN_ENQ, 32'h0000_0000);
    send_request(FN_ENQ, 32'hFFFF_FFFF);
    send_request(FN_ENQ, 32'h0000_0001);
    send_request(FN_ENQ, 32'h5555_5555);
    send_request(FN_ENQ, 32'hAAAA_AAAA);
    send_request(FN_ENQ, 32'h7FFF_FFFF);
    for (int i = 0; i < 8; i++) send_request(FN_ENQ, 32'h0000_0100 + i);

    // Enqueue on a full queue is dropped.
    send_request(FN_ENQ, 32'hDEAD_BEEF);
    // The duplicate nearest the head goes first.
    send_request(FN_REM, 32'h7FFF_FFFF);
    send_request(FN_REM, 32'h1234_5678);
    send_request(FN_REM, 32'h8000_0000);
    send_request(FN_REM, 32'h0000_0107);
    send_request(FN_DEQ, 32'h0000_0000);
    send_request(FN_NOP, 32'h0BAD_F00D);
    drain_results();

    // Random phases, each with its own mix of operations.
    sent = 0;
    while (sent < 1950) begin
      enq_pct   = $urandom_range(10, 90);
      phase_len = $urandom_range(20, 60);
      no_idle   = ($urandom_range(0, 4) == 0);
      value_pool[$urandom_range(0, 5)] = $urandom();
      for (int k = 0; k < phase_len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < enq_pct) begin
          fn = FN_ENQ;
        end else begin
          pick = $urandom_range(0, 9);
          if (pick < 4) fn = FN_DEQ;
          else if (pick < 9) fn = FN_REM;
          else fn = FN_NOP;
        end
        send_request(fn, pick_value(fn == FN_REM ? 75 : 50));
        sent++;
      end
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    // Wait for the last results, then a margin for anything stray.
    drain_results();
    no_idle = 1'b0;
    repeat (60) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("fifo_queue_with_remove_by_value_tb: PASS");
    end else begin
      $display("fifo_queue_with_remove_by_value_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> fifo_queue_with_remove_by_value.f
src/fqrv_pkg.sv
src/fqrv_store.sv
src/fqrv_ctrl.sv
src/fifo_queue_with_remove_by_value.sv
tb/sv/queue_result_checker.sv
tb/sv/fifo_queue_with_remove_by_value_tb.sv
